### design/jacobi_grid_relaxation_assert.svh
// ----------------------------------------------------------------------------
// jacobi grid relaxation assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef JACOBI_GRID_RELAXATION_ASSERT_SVH
`define JACOBI_GRID_RELAXATION_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define JGR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define JGR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/jgr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jgr_pkg
// widths, codes and reset values shared by the jacobi grid relaxation block
// ----------------------------------------------------------------------------
package jgr_pkg;

  localparam int DEF_MAX_SIDE = 64;

  localparam int OPCODE_W    = 2;
  localparam int INDEX_W     = 12;
  localparam int VALUE_W     = 32;
  localparam int SWEEPS_W    = 16;
  localparam int GRID_SIZE_W = 7;
  localparam int PREC_W      = 31;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 31;
  localparam int ACC_W       = VALUE_W + 2;

  localparam logic [GRID_SIZE_W-1:0] GRID_SIZE_RST  = GRID_SIZE_W'(10);
  localparam logic [PREC_W-1:0]      PRECISION_RST  = PREC_W'(1);
  localparam logic [SWEEPS_W-1:0]    MAX_SWEEPS_RST = {SWEEPS_W{1'b1}};

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD = 2'd0,
    OP_RUN  = 2'd1,
    OP_READ = 2'd2
  } opcode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GRID_SIZE  = 2'd0,
    REG_PRECISION  = 2'd1,
    REG_MAX_SWEEPS = 2'd2
  } reg_index_t;

endpackage

### design/jgr_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jgr_req_if
// command channel: load, run or read word with valid/ready handshake
// ----------------------------------------------------------------------------
interface jgr_req_if import jgr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OPCODE_W-1:0]       opcode;
  logic [INDEX_W-1:0]        cell_index;
  logic signed [VALUE_W-1:0] cell_value;

  modport source (output valid, output opcode, output cell_index, output cell_value,
                  input ready);
  modport sink (input valid, input opcode, input cell_index, input cell_value,
                output ready);
endinterface

### design/jgr_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jgr_rsp_if
// result channel: read value or run summary with valid/ready handshake
// ----------------------------------------------------------------------------
interface jgr_rsp_if import jgr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] read_value;
  logic [SWEEPS_W-1:0]       sweep_count;
  logic                      converged;

  modport source (output valid, output read_value, output sweep_count,
                  output converged, input ready);
  modport sink (input valid, input read_value, input sweep_count,
                input converged, output ready);
endinterface

### design/jacobi_grid_relaxation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jacobi_grid_relaxation
// 2-d laplace jacobi relaxation over a square q16.16 grid held in two memories
// ----------------------------------------------------------------------------
//  channel  dir  handshake        word
//  req      in   valid / ready    opcode, cell_index, cell_value
//  rsp      out  valid / ready    read_value, sweep_count, converged
//  cfg      in   cfg_we only      cfg_index, cfg_data
//
//  load writes both grids. run steps each interior cell through up, down,
//  left, right, center and update states, paced by the single read port of the
//  source grid (five reads per cell) and the one shared adder. reset (rst,
//  synchronous) clears control, the grid select and the config registers; the
//  grid memories are not cleared. req is held off while a command is in
//  flight or while a result waits on rsp and rsp.ready is low.
// ----------------------------------------------------------------------------
`include "jacobi_grid_relaxation_assert.svh"

module jacobi_grid_relaxation import jgr_pkg::*; #(
  parameter int MAX_SIDE = DEF_MAX_SIDE
) (
  input  logic                   clk,
  input  logic                   rst,
  jgr_req_if.sink                req,
  jgr_rsp_if.source              rsp,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SZ_W   = (GRID_SIZE_W > SIDE_W) ? GRID_SIZE_W : SIDE_W;
  localparam int NN_W   = 2 * SIDE_W;
  localparam int CMP_W  = (INDEX_W > NN_W) ? INDEX_W : NN_W;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_UP, S_DOWN, S_LEFT, S_RIGHT, S_CENTER, S_UPDATE, S_END
  } state_t;

  state_t state;

  // configuration registers
  logic [GRID_SIZE_W-1:0] grid_size;
  logic [PREC_W-1:0]      precision;
  logic [SWEEPS_W-1:0]    max_sweeps;

  // grid memories
  logic [VALUE_W-1:0] mem_a [DEPTH];
  logic [VALUE_W-1:0] mem_b [DEPTH];
  logic [VALUE_W-1:0] rd_a, rd_b, rd_src;
  logic               we_a, we_b;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic [VALUE_W-1:0] wr_data;

  // sweep walk
  logic                cur_b;
  logic [ADDR_W-1:0]   at;
  logic [SIDE_W-1:0]   row, col;
  logic [SWEEPS_W-1:0] sweeps, sweeps_next, limit;
  logic                sweep_ok, sweep_ok_eff;
  logic                diff_pend, bad;
  logic [ACC_W-1:0]    acc, diff;
  logic                rd_ok;
  logic                in_interior;

  // output word
  logic                out_valid;
  logic [VALUE_W-1:0]  out_value;
  logic [SWEEPS_W-1:0] out_count;
  logic                out_conv;

  // derived grid geometry
  logic [SZ_W-1:0]   sz_ext;
  logic [SIDE_W-1:0] n, n_m2;
  logic [NN_W-1:0]   nn;
  logic [ADDR_W-1:0] n_a, idx_addr;
  logic              in_range, accept, last_cell, row_end;

  // shared adder
  logic [ACC_W-1:0]   op_a, op_b, sum;
  logic               cin;
  logic [VALUE_W-1:0] next_val;
  logic [ACC_W-1:0]   prec_s;

  // side length clamped to 3..MAX_SIDE
  always_comb begin
    sz_ext = SZ_W'(grid_size);
    if (sz_ext < SZ_W'(3)) begin
      n = SIDE_W'(3);
    end else if (sz_ext > SZ_W'(MAX_SIDE)) begin
      n = SIDE_W'(MAX_SIDE);
    end else begin
      n = SIDE_W'(sz_ext);
    end
  end

  assign n_m2      = n - SIDE_W'(2);
  assign nn        = NN_W'(n) * NN_W'(n);
  assign n_a       = ADDR_W'(n);
  assign idx_addr  = ADDR_W'(req.cell_index);
  assign in_range  = CMP_W'(req.cell_index) < CMP_W'(nn);
  assign limit     = (max_sweeps == '0) ? SWEEPS_W'(1) : max_sweeps;
  assign row_end   = (col == n_m2);
  assign last_cell = row_end && (row == n_m2);
  assign in_interior = (row >= SIDE_W'(1)) && (row <= n_m2) &&
                       (col >= SIDE_W'(1)) && (col <= n_m2);

  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  assign rsp.valid       = out_valid;
  assign rsp.read_value  = out_value;
  assign rsp.sweep_count = out_count;
  assign rsp.converged   = out_conv;

  assign rd_src = cur_b ? rd_b : rd_a;

  // floor of the neighbour sum over four
  assign next_val = acc[ACC_W-1:2];

  // one adder: neighbour accumulation, then center minus new value
  always_comb begin
    op_a = acc;
    op_b = {{(ACC_W-VALUE_W){rd_src[VALUE_W-1]}}, rd_src};
    cin  = 1'b0;
    case (state)
      S_DOWN: begin
        op_a = '0;
      end
      S_UPDATE: begin
        op_a = {{(ACC_W-VALUE_W){rd_src[VALUE_W-1]}}, rd_src};
        op_b = ~{{(ACC_W-VALUE_W){next_val[VALUE_W-1]}}, next_val};
        cin  = 1'b1;
      end
      default: ;
    endcase
  end

  assign sum = op_a + op_b + ACC_W'(cin);

  // change check on the registered difference, in the cycle after each update
  assign prec_s     = ACC_W'(precision);
  assign bad        = diff_pend && (($signed(diff) > $signed(prec_s)) ||
                                    ($signed(diff) < -$signed(prec_s)));
  assign sweep_ok_eff = sweep_ok && !bad;
  assign sweeps_next = sweeps + SWEEPS_W'(1);

  // source read address per phase of the cell
  always_comb begin
    case (state)
      S_IDLE:   rd_addr = idx_addr;
      S_UP:     rd_addr = at - n_a;
      S_DOWN:   rd_addr = at + n_a;
      S_LEFT:   rd_addr = at - ADDR_W'(1);
      S_RIGHT:  rd_addr = at + ADDR_W'(1);
      default:  rd_addr = at;
    endcase
  end

  // loads go to both grids, sweep updates to the destination grid only
  always_comb begin
    logic load_we;
    load_we = accept && (req.opcode == OP_LOAD) && in_range;
    we_a    = load_we || ((state == S_UPDATE) && cur_b);
    we_b    = load_we || ((state == S_UPDATE) && !cur_b);
    wr_addr = load_we ? idx_addr : at;
    wr_data = load_we ? req.cell_value : next_val;
  end

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[wr_addr] <= wr_data;
    end
    rd_a <= mem_a[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[wr_addr] <= wr_data;
    end
    rd_b <= mem_b[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      cur_b      <= 1'b0;
      diff_pend  <= 1'b0;
      grid_size  <= GRID_SIZE_RST;
      precision  <= PRECISION_RST;
      max_sweeps <= MAX_SWEEPS_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_SIZE:  grid_size  <= cfg_data[GRID_SIZE_W-1:0];
          REG_PRECISION:  precision  <= cfg_data[PREC_W-1:0];
          REG_MAX_SWEEPS: max_sweeps <= cfg_data[SWEEPS_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end

      // difference of an update is checked in the cycle after it
      diff_pend <= (state == S_UPDATE);

      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req.opcode)
              OP_RUN: begin
                at       <= n_a + ADDR_W'(1);
                row      <= SIDE_W'(1);
                col      <= SIDE_W'(1);
                sweeps   <= '0;
                sweep_ok <= 1'b1;
                state    <= S_UP;
              end
              OP_READ: begin
                rd_ok <= in_range;
                state <= S_READ;
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          out_valid <= 1'b1;
          out_value <= rd_ok ? rd_src : '0;
          out_count <= '0;
          out_conv  <= 1'b0;
          state     <= S_IDLE;
        end
        S_UP: begin
          // fold the previous cell's change check into the sweep flag
          if (bad) begin
            sweep_ok <= 1'b0;
          end
          state <= S_DOWN;
        end
        S_DOWN: begin
          acc   <= sum;
          state <= S_LEFT;
        end
        S_LEFT: begin
          acc   <= sum;
          state <= S_RIGHT;
        end
        S_RIGHT: begin
          acc   <= sum;
          state <= S_CENTER;
        end
        S_CENTER: begin
          acc   <= sum;
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          diff <= sum;
          if (last_cell) begin
            state <= S_END;
          end else begin
            if (row_end) begin
              // skip the right and left border cells
              col <= SIDE_W'(1);
              row <= row + SIDE_W'(1);
              at  <= at + ADDR_W'(3);
            end else begin
              col <= col + SIDE_W'(1);
              at  <= at + ADDR_W'(1);
            end
            state <= S_UP;
          end
        end
        S_END: begin
          cur_b  <= !cur_b;
          sweeps <= sweeps_next;
          if (sweep_ok_eff || (sweeps_next >= limit)) begin
            out_valid <= 1'b1;
            out_value <= '0;
            out_count <= sweeps_next;
            out_conv  <= sweep_ok_eff;
            state     <= S_IDLE;
          end else begin
            at       <= n_a + ADDR_W'(1);
            row      <= SIDE_W'(1);
            col      <= SIDE_W'(1);
            sweep_ok <= 1'b1;
            state    <= S_UP;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a run never reports more sweeps than its limit
  `JGR_ASSERT_SAME(a_count_limit, rsp.valid, rsp.sweep_count <= limit, "sweep count over limit")
  // the walk only ever updates interior cells
  `JGR_ASSERT_SAME(a_interior, state == S_UPDATE, in_interior, "update outside interior")
  // grids swap roles exactly at the end of each sweep
  `JGR_ASSERT_NEXT(a_swap, state == S_END, cur_b != $past(cur_b), "grids not swapped")
  // no new command is taken in the update and end states of a sweep
  `JGR_ASSERT_SAME(a_busy, (state == S_UPDATE) || (state == S_END), !req.ready, "taken mid sweep")

endmodule
